FILE: src/aspect_fit_rect_scaler_core_macros.svh
// Assertion macros shared by the aspect-fit scaler RTL.
// Users must have clk_i and rst_ni in scope.
`ifndef ASPECT_FIT_RECT_SCALER_CORE_MACROS_SVH
`define ASPECT_FIT_RECT_SCALER_CORE_MACROS_SVH

`define AFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define AFR_ASSERT_IMPL(label, ante, cons, msg) \
  `AFR_ASSERT(label, (ante) |-> (cons), msg)

`endif

FILE: src/afr_pkg.sv
// Types, widths and register codes of the aspect-fit scaler.
// No dependencies.
package afr_pkg;

  localparam int CoordW          = 16;
  localparam int DimW            = 15;
  localparam int OutW            = 32;
  localparam int MagW            = 32;
  localparam int RemW            = DimW + 1;
  localparam int NumLanes        = 7;
  localparam int DivBitsPerStage = 4;
  localparam int DivStages       = MagW / DivBitsPerStage;
  localparam int CfgIdxW         = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DESIGN_WIDTH  = 1'b0,
    CFG_DESIGN_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [OutW-1:0]   word_t;

  typedef struct packed {
    coord_t          nx;
    coord_t          ny;
    coord_t          nw;
    coord_t          nh;
    coord_t          sx;
    coord_t          sy;
    coord_t          sw;
    coord_t          sh;
    logic [DimW-1:0] dw;
    logic [DimW-1:0] dh;
    logic            usable;
    logic            fit_h;
  } geom_t;

  typedef struct packed {
    logic [NumLanes-1:0][MagW-1:0] work;
    logic [NumLanes-1:0][RemW-1:0] rem;
    logic [NumLanes-1:0]           neg;
    logic [DimW-1:0]               den;
    geom_t                         geom;
  } div_t;

endpackage

FILE: src/afr_if.sv
// Channel interfaces of the aspect-fit scaler: input, output and config.
// Depends on afr_pkg.
interface afr_in_if import afr_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t native_x;
  coord_t native_y;
  coord_t native_width;
  coord_t native_height;
  coord_t safe_in_x;
  coord_t safe_in_y;
  coord_t safe_in_width;
  coord_t safe_in_height;
  modport source(output valid, native_x, native_y, native_width, native_height,
                 safe_in_x, safe_in_y, safe_in_width, safe_in_height, input ready);
  modport sink(input valid, native_x, native_y, native_width, native_height,
               safe_in_x, safe_in_y, safe_in_width, safe_in_height, output ready);
endinterface

interface afr_out_if import afr_pkg::*;;
  logic  valid;
  logic  ready;
  word_t screen_x;
  word_t screen_y;
  word_t screen_width;
  word_t screen_height;
  word_t safe_out_x;
  word_t safe_out_y;
  word_t safe_out_width;
  word_t safe_out_height;
  modport source(output valid, screen_x, screen_y, screen_width, screen_height,
                 safe_out_x, safe_out_y, safe_out_width, safe_out_height, input ready);
  modport sink(input valid, screen_x, screen_y, screen_width, screen_height,
               safe_out_x, safe_out_y, safe_out_width, safe_out_height, output ready);
endinterface

interface afr_cfg_if import afr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DimW-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: src/afr_front.sv
// Front of the scaler: size fallbacks, cross products, axis choice and
// scaling products. Two register stages. Depends on afr_pkg, afr_if.
module afr_front import afr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  afr_in_if.sink          in_i,
  input  logic [DimW-1:0] design_width_i,
  input  logic [DimW-1:0] design_height_i,
  output logic            valid_o,
  input  logic            ready_i,
  output div_t            data_o
);

  typedef struct packed {
    geom_t             g;
    logic [2*DimW-1:0] p_ds;
    logic [2*DimW-1:0] p_sd;
  } s1_t;

  logic  v1_q, v2_q, rdy1, rdy2;
  s1_t   s1_d, s1_q;
  div_t  d2_d, d2_q;

  assign rdy2       = !v2_q || ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_i.ready = rdy1;
  assign valid_o    = v2_q;
  assign data_o     = d2_q;

  always_comb begin
    logic            native_unset, safe_unset, cfg_set;
    native_unset = (in_i.native_width <= 0) || (in_i.native_height <= 0);
    s1_d = '0;
    s1_d.g.nx = native_unset ? coord_t'(0) : in_i.native_x;
    s1_d.g.ny = native_unset ? coord_t'(0) : in_i.native_y;
    s1_d.g.nw = native_unset ? coord_t'({1'b0, design_width_i}) : in_i.native_width;
    s1_d.g.nh = native_unset ? coord_t'({1'b0, design_height_i}) : in_i.native_height;
    safe_unset = (in_i.safe_in_width <= 0) || (in_i.safe_in_height <= 0);
    s1_d.g.sx = safe_unset ? s1_d.g.nx : in_i.safe_in_x;
    s1_d.g.sy = safe_unset ? s1_d.g.ny : in_i.safe_in_y;
    s1_d.g.sw = safe_unset ? s1_d.g.nw : in_i.safe_in_width;
    s1_d.g.sh = safe_unset ? s1_d.g.nh : in_i.safe_in_height;
    cfg_set = (design_width_i != '0) && (design_height_i != '0);
    s1_d.g.dw = cfg_set ? design_width_i : s1_d.g.sw[DimW-1:0];
    s1_d.g.dh = cfg_set ? design_height_i : s1_d.g.sh[DimW-1:0];
    s1_d.g.usable = (s1_d.g.dw != '0) && (s1_d.g.dh != '0);
    s1_d.p_ds = (2*DimW)'(s1_d.g.dw) * (2*DimW)'(s1_d.g.sh[DimW-1:0]);
    s1_d.p_sd = (2*DimW)'(s1_d.g.sw[DimW-1:0]) * (2*DimW)'(s1_d.g.dh);
  end

  always_comb begin
    logic                 fit_h;
    logic [DimW-1:0]      num;
    coord_t               lane_v [NumLanes];
    logic [CoordW-1:0]    mag;
    fit_h = s1_q.p_ds <= s1_q.p_sd;
    num   = fit_h ? s1_q.g.dh : s1_q.g.dw;
    lane_v[0] = s1_q.g.nx;
    lane_v[1] = s1_q.g.ny;
    lane_v[2] = s1_q.g.nw;
    lane_v[3] = s1_q.g.nh;
    lane_v[4] = s1_q.g.sx;
    lane_v[5] = s1_q.g.sy;
    lane_v[6] = fit_h ? s1_q.g.sw : s1_q.g.sh;
    d2_d = '0;
    d2_d.geom       = s1_q.g;
    d2_d.geom.fit_h = fit_h;
    d2_d.den = fit_h ? s1_q.g.sh[DimW-1:0] : s1_q.g.sw[DimW-1:0];
    for (int i = 0; i < NumLanes; i++) begin
      d2_d.neg[i]  = lane_v[i][CoordW-1];
      mag          = d2_d.neg[i] ? (~lane_v[i] + 1'b1) : lane_v[i];
      d2_d.work[i] = MagW'(mag) * MagW'(num);
      d2_d.rem[i]  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_i.valid) s1_q <= s1_d;
    if (rdy2 && v1_q) d2_q <= d2_d;
  end

endmodule

FILE: src/afr_div_stage.sv
// One stage of the pipelined restoring divider, several quotient bits on
// all lanes at once. Depends on afr_pkg and the macro header.
`include "aspect_fit_rect_scaler_core_macros.svh"
module afr_div_stage import afr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  div_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output div_t data_o
);

  logic            v_q;
  div_t            data_d, data_q;
  logic [RemW-1:0] den_ext;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign data_o  = data_q;
  assign den_ext = RemW'(data_q.den);

  always_comb begin
    logic [RemW-1:0] rem_sh;
    data_d = data_i;
    for (int i = 0; i < NumLanes; i++) begin
      for (int s = 0; s < DivBitsPerStage; s++) begin
        rem_sh            = {data_d.rem[i][RemW-2:0], data_d.work[i][MagW-1]};
        data_d.work[i]    = {data_d.work[i][MagW-2:0], 1'b0};
        if (rem_sh >= RemW'(data_i.den)) begin
          data_d.rem[i]     = rem_sh - RemW'(data_i.den);
          data_d.work[i][0] = 1'b1;
        end else begin
          data_d.rem[i]     = rem_sh;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  `AFR_ASSERT_IMPL(a_rem_lane0_lt_den, v_q && data_q.geom.usable, data_q.rem[0] < den_ext, "divider remainder out of range on lane 0")
  `AFR_ASSERT_IMPL(a_rem_lane6_lt_den, v_q && data_q.geom.usable, data_q.rem[6] < den_ext, "divider remainder out of range on lane 6")

endmodule

FILE: src/afr_back.sv
// Back of the scaler: sign restore, fitted axis, centring offset and
// output register. Three stages. Depends on afr_pkg, afr_if, macros.
`include "aspect_fit_rect_scaler_core_macros.svh"
module afr_back import afr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  div_t    data_i,
  afr_out_if.source out_o
);

  logic  v1_q, v2_q, v3_q, rdy1, rdy2, rdy3;
  word_t r1_d [8];
  word_t r1_q [8];
  word_t r2_q [8];
  word_t r3_q [8];
  word_t dw1_q, dh1_q;
  logic  usable1_q, fit1_q, usable2_q, fit2_q, usable3_q, fit3_q;
  word_t ox_d, oy_d, ox_q, oy_q;

  assign rdy3    = !v3_q || out_o.ready;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_comb begin
    word_t  sq [NumLanes];
    geom_t  g;
    g = data_i.geom;
    for (int i = 0; i < NumLanes; i++) begin
      sq[i] = data_i.neg[i] ? -word_t'(data_i.work[i]) : word_t'(data_i.work[i]);
    end
    if (g.usable) begin
      for (int i = 0; i < 6; i++) r1_d[i] = sq[i];
      r1_d[6] = g.fit_h ? sq[6] : word_t'({1'b0, g.dw});
      r1_d[7] = g.fit_h ? word_t'({1'b0, g.dh}) : sq[6];
    end else begin
      r1_d[0] = word_t'(g.nx);
      r1_d[1] = word_t'(g.ny);
      r1_d[2] = word_t'(g.nw);
      r1_d[3] = word_t'(g.nh);
      r1_d[4] = word_t'(g.sx);
      r1_d[5] = word_t'(g.sy);
      r1_d[6] = word_t'(g.sw);
      r1_d[7] = word_t'(g.sh);
    end
  end

  always_comb begin
    word_t dx, dy, hx, hy;
    dx   = r1_q[6] - dw1_q;
    dy   = r1_q[7] - dh1_q;
    hx   = (dx + word_t'({1'b0, dx[OutW-1]})) >>> 1;
    hy   = (dy + word_t'({1'b0, dy[OutW-1]})) >>> 1;
    ox_d = usable1_q ? r1_q[4] + hx : '0;
    oy_d = usable1_q ? r1_q[5] + hy : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      r1_q      <= r1_d;
      dw1_q     <= word_t'({1'b0, data_i.geom.dw});
      dh1_q     <= word_t'({1'b0, data_i.geom.dh});
      usable1_q <= data_i.geom.usable;
      fit1_q    <= data_i.geom.fit_h;
    end
    if (rdy2 && v1_q) begin
      r2_q      <= r1_q;
      ox_q      <= ox_d;
      oy_q      <= oy_d;
      usable2_q <= usable1_q;
      fit2_q    <= fit1_q;
    end
    if (rdy3 && v2_q) begin
      r3_q[0]   <= r2_q[0] - ox_q;
      r3_q[1]   <= r2_q[1] - oy_q;
      r3_q[2]   <= r2_q[2];
      r3_q[3]   <= r2_q[3];
      r3_q[4]   <= r2_q[4] - ox_q;
      r3_q[5]   <= r2_q[5] - oy_q;
      r3_q[6]   <= r2_q[6];
      r3_q[7]   <= r2_q[7];
      usable3_q <= usable2_q;
      fit3_q    <= fit2_q;
    end
  end

  assign out_o.valid           = v3_q;
  assign out_o.screen_x        = r3_q[0];
  assign out_o.screen_y        = r3_q[1];
  assign out_o.screen_width    = r3_q[2];
  assign out_o.screen_height   = r3_q[3];
  assign out_o.safe_out_x      = r3_q[4];
  assign out_o.safe_out_y      = r3_q[5];
  assign out_o.safe_out_width  = r3_q[6];
  assign out_o.safe_out_height = r3_q[7];

  `AFR_ASSERT_IMPL(a_fit_h_safe_y_zero, v3_q && usable3_q && fit3_q, r3_q[5] == '0, "height fit must put safe top at the origin")
  `AFR_ASSERT_IMPL(a_fit_w_safe_x_zero, v3_q && usable3_q && !fit3_q, r3_q[4] == '0, "width fit must put safe left at the origin")

endmodule

FILE: src/aspect_fit_rect_scaler_core.sv
// Aspect-fit rectangle scaler, top level.
// Pipeline: 2 front stages, 8 divider stages, 3 back stages.
// Throughput one word per cycle; each stage stalls only when full and blocked.
// The divider pipeline retires 4 quotient bits per stage on all 7 lanes.
// Reset clears all valid bits and both design size registers to 0.
module aspect_fit_rect_scaler_core import afr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  afr_cfg_if.sink    cfg_i,
  afr_in_if.sink     in_i,
  afr_out_if.source  out_o
);

  logic [DimW-1:0] design_width_q, design_height_q;
  logic            v   [DivStages+1];
  logic            rdy [DivStages+1];
  div_t            d   [DivStages+1];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      design_width_q  <= '0;
      design_height_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_DESIGN_WIDTH:  design_width_q  <= cfg_i.data;
        CFG_DESIGN_HEIGHT: design_height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  afr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_i),
    .design_width_i  (design_width_q),
    .design_height_i (design_height_q),
    .valid_o         (v[0]),
    .ready_i         (rdy[0]),
    .data_o          (d[0])
  );

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    afr_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[k]),
      .ready_o (rdy[k]),
      .data_i  (d[k]),
      .valid_o (v[k+1]),
      .ready_i (rdy[k+1]),
      .data_o  (d[k+1])
    );
  end

  afr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v[DivStages]),
    .ready_o (rdy[DivStages]),
    .data_i  (d[DivStages]),
    .out_o   (out_o)
  );

endmodule

FILE: verif/tb.sv
// Testbench for aspect_fit_rect_scaler_core: random and directed rectangle pairs
// checked against a built-in predictor of the letterbox fit.
// Depends on afr_pkg, afr_if and the RTL.
`timescale 1ns / 100ps

module tb;
  import afr_pkg::*;

  typedef struct packed {
    word_t sx, sy, sw, sh, ax, ay, aw, ah;
  } fit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  afr_cfg_if cfg_bus();
  afr_in_if  in_bus();
  afr_out_if out_bus();

  aspect_fit_rect_scaler_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_bus), .in_i(in_bus),
    .out_o(out_bus)
  );

  logic [DimW-1:0] des_w = '0, des_h = '0;
  fit_t fit_q[$];
  int   send_idle_pct = 0, recv_stall_pct = 0;
  int   errors = 0, quiet = 0;

  initial begin
    cfg_bus.valid = 1'b0; cfg_bus.index = CFG_DESIGN_WIDTH; cfg_bus.data = '0;
    in_bus.valid = 1'b0;
    in_bus.native_x = '0; in_bus.native_y = '0; in_bus.native_width = '0;
    in_bus.native_height = '0; in_bus.safe_in_x = '0; in_bus.safe_in_y = '0;
    in_bus.safe_in_width = '0; in_bus.safe_in_height = '0;
    out_bus.ready = 1'b0;
  end

  function automatic longint wrap(longint v);
    return longint'(signed'(v[31:0]));
  endfunction

  function automatic longint scl(longint v, longint num, longint den);
    if (den == 0) return 0;
    return wrap((v * num) / den);
  endfunction

  function automatic fit_t predict_fit(coord_t f[8]);
    longint nx, ny, nw, nh, sx, sy, sw, sh, dw, dh, num, den, ox, oy;
    longint r[8];
    bit fh;
    fit_t o;
    nx = f[0]; ny = f[1]; nw = f[2]; nh = f[3];
    sx = f[4]; sy = f[5]; sw = f[6]; sh = f[7];
    dw = des_w; dh = des_h;
    if (nw <= 0 || nh <= 0) begin
      nx = 0; ny = 0; nw = dw; nh = dh;
    end
    if (sw <= 0 || sh <= 0) begin
      sx = nx; sy = ny; sw = nw; sh = nh;
    end
    if (dw <= 0 || dh <= 0) begin
      dw = sw; dh = sh;
    end
    if (dw <= 0 || dh <= 0) begin
      r = '{nx, ny, nw, nh, sx, sy, sw, sh};
    end else begin
      fh = dw * sh <= sw * dh;
      num = fh ? dh : dw;
      den = fh ? sh : sw;
      r[0] = scl(nx, num, den); r[1] = scl(ny, num, den);
      r[2] = scl(nw, num, den); r[3] = scl(nh, num, den);
      r[4] = scl(sx, num, den); r[5] = scl(sy, num, den);
      r[6] = fh ? scl(sw, num, den) : dw;
      r[7] = fh ? dh : scl(sh, num, den);
      ox = wrap(r[4] + wrap(r[6] - dw) / 2);
      oy = wrap(r[5] + wrap(r[7] - dh) / 2);
      r[0] = wrap(r[0] - ox); r[1] = wrap(r[1] - oy);
      r[4] = wrap(r[4] - ox); r[5] = wrap(r[5] - oy);
    end
    o = '{r[0][31:0], r[1][31:0], r[2][31:0], r[3][31:0],
          r[4][31:0], r[5][31:0], r[6][31:0], r[7][31:0]};
    return o;
  endfunction

  task automatic send_rects(coord_t f[8]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.native_x <= f[0]; in_bus.native_y <= f[1];
    in_bus.native_width <= f[2]; in_bus.native_height <= f[3];
    in_bus.safe_in_x <= f[4]; in_bus.safe_in_y <= f[5];
    in_bus.safe_in_width <= f[6]; in_bus.safe_in_height <= f[7];
    fit_q.push_back(predict_fit(f));
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (fit_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_design(logic [DimW-1:0] w, logic [DimW-1:0] h);
    drain();
    repeat (16) @(posedge clk_i);
    cfg_bus.valid <= 1'b1; cfg_bus.index <= CFG_DESIGN_WIDTH; cfg_bus.data <= w;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.index <= CFG_DESIGN_HEIGHT; cfg_bus.data <= h;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
    des_w = w; des_h = h;
  endtask

  function automatic coord_t rnd_coord();
    case ($urandom_range(5))
      0: return coord_t'($urandom);
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      2: return coord_t'($urandom_range(4) - 2);
      default: return coord_t'($urandom_range(4000) - 2000);
    endcase
  endfunction

  function automatic coord_t rnd_size();
    case ($urandom_range(9))
      0: return coord_t'(-$urandom_range(32768));
      1: return 16'sd0;
      2: return coord_t'($urandom);
      3: return 16'sh7fff;
      default: return coord_t'($urandom_range(3000, 1));
    endcase
  endfunction

  task automatic test_directed();
    coord_t f[8];
    logic [DimW-1:0] dims[5] = '{0, 1, 32767, 640, 480};
    foreach (dims[i]) begin
      write_design(dims[i], dims[(i + 1) % 5]);
      f = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 1, 16'sh7fff};
      send_rects(f);
      f = '{5, 7, 0, 10, 3, 4, 20, 30};
      send_rects(f);
      f = '{5, 7, 100, 50, 3, 4, -1, 30};
      send_rects(f);
      f = '{-9, 11, 16'sh8000, -3, 2, 2, 0, 0};
      send_rects(f);
      f = '{-16'sd100, 16'sd33, 16'sd1, 16'sd1, -16'sd7, 16'sd9, 16'sd3, 16'sd1};
      send_rects(f);
    end
  endtask

  task automatic test_random(int n);
    coord_t f[8];
    repeat (n) begin
      f[0] = rnd_coord(); f[1] = rnd_coord(); f[2] = rnd_size(); f[3] = rnd_size();
      f[4] = rnd_coord(); f[5] = rnd_coord(); f[6] = rnd_size(); f[7] = rnd_size();
      send_rects(f);
    end
  endtask

  task automatic test_phases();
    int idle_s[4] = '{0, 52, 0, 15};
    int idle_r[4] = '{0, 0, 52, 15};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_s[p]; recv_stall_pct = idle_r[p];
      case (p)
        0: write_design(32767, 32767);
        1: write_design(0, 0);
        2: write_design(1, 1);
        default: write_design(
          DimW'($urandom_range(32767)), DimW'($urandom_range(32767)));
      endcase
      test_random(150);
      write_design(DimW'($urandom_range(2000)),
                   DimW'($urandom_range(2000)));
      test_random(150);
      drain();
      test_random(150);
    end
    send_idle_pct = 0; recv_stall_pct = 0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    fit_t got, want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.screen_x, out_bus.screen_y, out_bus.screen_width,
              out_bus.screen_height, out_bus.safe_out_x, out_bus.safe_out_y,
              out_bus.safe_out_width, out_bus.safe_out_height};
      if (fit_q.size() == 0) begin
        $error("unexpected word"); errors++;
      end else begin
        want = fit_q.pop_front();
        if (got.sx != want.sx) begin $error("screen_x exp %0d got %0d", want.sx, got.sx); errors++; end
        if (got.sy != want.sy) begin $error("screen_y exp %0d got %0d", want.sy, got.sy); errors++; end
        if (got.sw != want.sw) begin $error("screen_width exp %0d got %0d", want.sw, got.sw); errors++; end
        if (got.sh != want.sh) begin $error("screen_height exp %0d got %0d", want.sh, got.sh); errors++; end
        if (got.ax != want.ax) begin $error("safe_out_x exp %0d got %0d", want.ax, got.ax); errors++; end
        if (got.ay != want.ay) begin $error("safe_out_y exp %0d got %0d", want.ay, got.ay); errors++; end
        if (got.aw != want.aw) begin $error("safe_out_width exp %0d got %0d", want.aw, got.aw); errors++; end
        if (got.ah != want.ah) begin $error("safe_out_height exp %0d got %0d", want.ah, got.ah); errors++; end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready) || fit_q.size() == 0)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_phases();
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && fit_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

FILE: aspect_fit_rect_scaler_core.f
+incdir+src
src/afr_pkg.sv
src/afr_if.sv
src/afr_front.sv
src/afr_div_stage.sv
src/afr_back.sv
src/aspect_fit_rect_scaler_core.sv
verif/tb.sv
